@@ rtl/dtsa_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dtsa_pkg
// Types, constants and the month length table for the date-time seconds adder.
// ---------------------------------------------------------------------------
package dtsa_pkg;

    localparam int unsigned ADD_W = 17;
    localparam logic [ADD_W-1:0] ADD_RESET = 17'd30;

    localparam int unsigned YEAR_W = 14;
    localparam int unsigned SUM_W  = 18;   // second + add_seconds
    localparam int unsigned MSUM_W = 12;   // minute + quotient of seconds
    localparam int unsigned HSUM_W = 7;    // hour + quotient of minutes

    localparam logic [4:0] MONTHS_PER_YEAR = 5'd12;
    localparam logic [5:0] SECS_PER_MIN    = 6'd60;
    localparam logic [6:0] HOURS_PER_DAY   = 7'd24;

    // reciprocal of 60 for an 18-bit dividend: floor(x * 279621 / 2^24)
    localparam logic [18:0] RECIP60_SEC = 19'd279621;
    localparam int unsigned RECIP60_SEC_SH = 24;
    // reciprocal of 60 for a 12-bit dividend: floor(x * 4370 / 2^18)
    localparam logic [12:0] RECIP60_MIN = 13'd4370;
    localparam int unsigned RECIP60_MIN_SH = 18;
    // divisibility by 25: (y * 20972) mod 2^19 < 20972 for 14-bit y
    localparam logic [14:0] RECIP25 = 15'd20972;
    localparam int unsigned RECIP25_SH = 19;

    typedef struct packed {
        logic [13:0] in_year;
        logic [3:0]  in_month;
        logic [4:0]  in_day;
        logic [4:0]  in_hour;
        logic [5:0]  in_minute;
        logic [5:0]  in_second;
    } in_item_t;

    typedef struct packed {
        logic [13:0] out_year;
        logic [3:0]  out_month;
        logic [4:0]  out_day;
        logic [4:0]  out_hour;
        logic [5:0]  out_minute;
        logic [5:0]  out_second;
    } out_item_t;

    // date-time in flight through the day carry stages
    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic        leap;
        logic [1:0]  carries;
    } work_t;

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        begin
            case (month)
                4'd2:    len = leap ? 5'd29 : 5'd28;
                4'd4:    len = 5'd30;
                4'd6:    len = 5'd30;
                4'd9:    len = 5'd30;
                4'd11:   len = 5'd30;
                default: len = 5'd31;
            endcase
            return len;
        end
    endfunction

endpackage

@@ rtl/dtsa_time_pipe.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dtsa_time_pipe
// Five-stage pipeline: adds the step to the seconds, carries seconds into
// minutes and minutes into hours, splits hours into day carries, and works
// out the leap flag of the input year.
// ---------------------------------------------------------------------------
module dtsa_time_pipe
    import dtsa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  in_item_t         in_item,
    input  logic [ADD_W-1:0] add_seconds,
    output logic             out_valid,
    output work_t            out_work
);

    logic [4:0] valid_reg;

    // stage 1
    in_item_t          s1_item_reg;
    logic [SUM_W-1:0]  s1_sum_reg;
    logic [RECIP25_SH-1:0] s1_yfrac_reg;
    // stage 2
    in_item_t          s2_item_reg;
    logic [SUM_W-1:0]  s2_sum_reg;
    logic [11:0]       s2_q_reg;
    logic              s2_leap_reg;
    // stage 3
    in_item_t          s3_item_reg;
    logic [MSUM_W-1:0] s3_msum_reg;
    logic [5:0]        s3_sec_reg;
    logic              s3_leap_reg;
    // stage 4
    in_item_t          s4_item_reg;
    logic [MSUM_W-1:0] s4_msum_reg;
    logic [5:0]        s4_q_reg;
    logic [5:0]        s4_sec_reg;
    logic              s4_leap_reg;
    // stage 5
    work_t             s5_work_reg;

    logic [28:0]       yprod;
    logic [36:0]       sprod;
    logic              div25;
    logic              leap_next;
    logic [SUM_W-1:0]  q60_x60;
    logic [SUM_W-1:0]  sec_rem;
    logic [24:0]       mprod;
    logic [MSUM_W-1:0] qm_x60;
    logic [MSUM_W-1:0] min_rem;
    logic [HSUM_W-1:0] hour_sum;
    work_t             s5_work_next;

    always_comb
    begin
        yprod = {1'b0, in_item.in_year} * RECIP25;
        sprod = {1'b0, s1_sum_reg} * {18'b0, RECIP60_SEC};

        // y % 100 == 0 iff y % 4 == 0 and y % 25 == 0; likewise 400 with 16
        div25     = s1_yfrac_reg < {4'b0, RECIP25};
        leap_next = ((s1_item_reg.in_year[1:0] == 2'b00) && !div25)
                 || ((s1_item_reg.in_year[3:0] == 4'b0000) && div25);

        q60_x60 = {s2_q_reg, 6'b0} - {4'b0, s2_q_reg, 2'b0};
        sec_rem = s2_sum_reg - q60_x60;

        mprod = {1'b0, s3_msum_reg} * {12'b0, RECIP60_MIN};

        qm_x60   = {s4_q_reg, 6'b0} - {4'b0, s4_q_reg, 2'b0};
        min_rem  = s4_msum_reg - qm_x60;
        hour_sum = {2'b0, s4_item_reg.in_hour} + {1'b0, s4_q_reg};

        s5_work_next.year   = s4_item_reg.in_year;
        s5_work_next.month  = s4_item_reg.in_month;
        s5_work_next.day    = s4_item_reg.in_day;
        s5_work_next.minute = min_rem[5:0];
        s5_work_next.second = s4_sec_reg;
        s5_work_next.leap   = s4_leap_reg;
        if (hour_sum >= {HOURS_PER_DAY[5:0], 1'b0})
        begin
            s5_work_next.carries = 2'd2;
            s5_work_next.hour    = 5'(hour_sum - {HOURS_PER_DAY[5:0], 1'b0});
        end
        else if (hour_sum >= HOURS_PER_DAY)
        begin
            s5_work_next.carries = 2'd1;
            s5_work_next.hour    = 5'(hour_sum - HOURS_PER_DAY);
        end
        else
        begin
            s5_work_next.carries = 2'd0;
            s5_work_next.hour    = hour_sum[4:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        s1_item_reg  <= in_item;
        s1_sum_reg   <= {12'b0, in_item.in_second} + {1'b0, add_seconds};
        s1_yfrac_reg <= yprod[RECIP25_SH-1:0];

        s2_item_reg <= s1_item_reg;
        s2_sum_reg  <= s1_sum_reg;
        s2_q_reg    <= sprod[RECIP60_SEC_SH+11:RECIP60_SEC_SH];
        s2_leap_reg <= leap_next;

        s3_item_reg <= s2_item_reg;
        s3_msum_reg <= {6'b0, s2_item_reg.in_minute} + s2_q_reg;
        s3_sec_reg  <= sec_rem[5:0];
        s3_leap_reg <= s2_leap_reg;

        s4_item_reg <= s3_item_reg;
        s4_msum_reg <= s3_msum_reg;
        s4_q_reg    <= mprod[RECIP60_MIN_SH+5:RECIP60_MIN_SH];
        s4_sec_reg  <= s3_sec_reg;
        s4_leap_reg <= s3_leap_reg;

        s5_work_reg <= s5_work_next;
    end

    assign out_valid = valid_reg[4];
    assign out_work  = s5_work_reg;

endmodule

@@ rtl/dtsa_day_step.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dtsa_day_step
// One register stage that applies a single pending day carry: the day moves
// on by one and rolls into the next month, and December (or any higher month) into the next year.
// ---------------------------------------------------------------------------
module dtsa_day_step
    import dtsa_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  work_t in_work,
    output logic  out_valid,
    output work_t out_work
);

    logic  valid_reg;
    work_t work_reg;
    work_t work_next;
    logic [4:0] len;
    logic [5:0] day_inc;
    logic [5:0] day_wrap;

    always_comb
    begin
        len       = month_len(in_work.month, in_work.leap);
        day_inc   = {1'b0, in_work.day} + 6'd1;
        day_wrap  = day_inc - {1'b0, len};
        work_next = in_work;
        if (in_work.carries != 2'd0)
        begin
            work_next.carries = in_work.carries - 2'd1;
            if (day_inc > {1'b0, len})
            begin
                // leap flag stays valid: a new year always starts in january
                work_next.day = day_wrap[4:0];
                if ({1'b0, in_work.month} >= MONTHS_PER_YEAR)
                begin
                    work_next.month = 4'd1;
                    work_next.year  = in_work.year + 14'd1;
                end
                else
                begin
                    work_next.month = in_work.month + 4'd1;
                end
            end
            else
            begin
                work_next.day = day_inc[4:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
    end

    assign out_valid = valid_reg;
    assign out_work  = work_reg;

endmodule

@@ rtl/date_time_seconds_adder_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// date_time_seconds_adder_top
// Adds the programmed number of seconds to a Gregorian date and time.
//
//   channel   ports                       handshake
//   input     start, busy, item           taken when start and not busy
//   result    done, result                one cycle, strobed by done
//   config    cfg_we, cfg_data            written when cfg_we
//
// seven register stages: five for the second/minute/hour carries and the
// leap flag, then one stage per possible day carry.
// an item taken on the input is registered through every stage onto result,
// where done strobes it for the receiver.
// one item per cycle; busy is always low since nothing downstream stalls.
// reset clears the valid bits and sets the step to 30 seconds.
// ---------------------------------------------------------------------------
module date_time_seconds_adder_top
    import dtsa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  in_item_t         item,
    output logic             done,
    output out_item_t        result,
    input  logic             cfg_we,
    input  logic [ADD_W-1:0] cfg_data
);

    logic [ADD_W-1:0] add_seconds_reg;
    logic  time_valid;
    work_t time_work;
    logic  day1_valid;
    work_t day1_work;
    logic  day2_valid;
    work_t day2_work;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            add_seconds_reg <= ADD_RESET;
        end
        else if (cfg_we)
        begin
            add_seconds_reg <= cfg_data;
        end
    end

    assign busy = 1'b0;

    dtsa_time_pipe u_time_pipe (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (start),
        .in_item     (item),
        .add_seconds (add_seconds_reg),
        .out_valid   (time_valid),
        .out_work    (time_work)
    );

    dtsa_day_step u_day_step1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (time_valid),
        .in_work   (time_work),
        .out_valid (day1_valid),
        .out_work  (day1_work)
    );

    dtsa_day_step u_day_step2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (day1_valid),
        .in_work   (day1_work),
        .out_valid (day2_valid),
        .out_work  (day2_work)
    );

    assign done              = day2_valid;
    assign result.out_year   = day2_work.year;
    assign result.out_month  = day2_work.month;
    assign result.out_day    = day2_work.day;
    assign result.out_hour   = day2_work.hour;
    assign result.out_minute = day2_work.minute;
    assign result.out_second = day2_work.second;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##7 done)
        else $error("item did not come out after seven cycles");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.out_hour < 5'd24) && (result.out_minute < 6'd60)
                 && (result.out_second < 6'd60))
        else $error("time field out of range on result");

    a_carries_used: assert property (@(posedge clk) disable iff (!rst_n)
        day2_valid |-> (day2_work.carries == 2'd0))
        else $error("day carry left over after last stage");

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Testbench for date_time_seconds_adder_top: drives date-time items through
// the start/busy handshake and checks every strobed result against a local
// calendar model. The step register is reprogrammed between phases, and the
// sender idles at several rates.
// ---------------------------------------------------------------------------
module tb;
    import dtsa_pkg::*;

    localparam int unsigned PIPE_DEPTH = 7;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned ITEMS_PER_PHASE = 102;

    class dt_scoreboard;
        localparam int unsigned SEC_PER_MIN = 60;
        localparam int unsigned MIN_PER_HOUR = 60;
        localparam int unsigned HOUR_PER_DAY = 24;
        localparam int unsigned MONTH_COUNT = 12;

        out_item_t   pending[$];
        int unsigned step_s;
        int unsigned errors;

        function new();
            step_s = 32'(ADD_RESET);
            errors = 0;
        endfunction

        static function int unsigned days_in(int unsigned y, int unsigned m);
            if (m == 2)
                return (((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0) ? 29 : 28;
            if (m == 4 || m == 6 || m == 9 || m == 11)
                return 30;
            return 31;
        endfunction

        function void set_step(int unsigned s);
            step_s = s & 32'h1ffff;
        endfunction

        function out_item_t shift_date_time(in_item_t it);
            int unsigned y, m, d, h, mi, s, carries;
            out_item_t o;
            y = 32'(it.in_year);
            m = 32'(it.in_month);
            d = 32'(it.in_day);
            h = 32'(it.in_hour);
            mi = 32'(it.in_minute);
            s = 32'(it.in_second) + step_s;
            mi += s / SEC_PER_MIN;
            s %= SEC_PER_MIN;
            h += mi / MIN_PER_HOUR;
            mi %= MIN_PER_HOUR;
            carries = h / HOUR_PER_DAY;
            h %= HOUR_PER_DAY;
            // bad months count as 31 days; an oversized day keeps rolling over
            for (int k = 0; k < carries; k++)
            begin
                d++;
                while (d > days_in(y, m))
                begin
                    d -= days_in(y, m);
                    m++;
                    if (m > MONTH_COUNT)
                    begin
                        m = 1;
                        y++;
                    end
                end
            end
            o.out_year = 14'(y);
            o.out_month = 4'(m);
            o.out_day = 5'(d);
            o.out_hour = 5'(h);
            o.out_minute = 6'(mi);
            o.out_second = 6'(s);
            return o;
        endfunction

        function void note_item(in_item_t it);
            pending.push_back(shift_date_time(it));
        endfunction

        function void check_field(string name, int unsigned e, int unsigned a);
            if (e != a)
            begin
                $error("%s: expected %0d, got %0d", name, e, a);
                errors++;
            end
        endfunction

        function void check_result(out_item_t r);
            out_item_t e;
            if (pending.size() == 0)
            begin
                $error("result with no item outstanding: %p", r);
                errors++;
                return;
            end
            e = pending.pop_front();
            check_field("out_year", 32'(e.out_year), 32'(r.out_year));
            check_field("out_month", 32'(e.out_month), 32'(r.out_month));
            check_field("out_day", 32'(e.out_day), 32'(r.out_day));
            check_field("out_hour", 32'(e.out_hour), 32'(r.out_hour));
            check_field("out_minute", 32'(e.out_minute), 32'(r.out_minute));
            check_field("out_second", 32'(e.out_second), 32'(r.out_second));
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    in_item_t         item = '0;
    logic             done;
    out_item_t        result;
    logic             cfg_we = 1'b0;
    logic [ADD_W-1:0] cfg_data = '0;

    dt_scoreboard sb = new();
    int unsigned  cycles = 0;

    date_time_seconds_adder_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .item     (item),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[date_time_seconds_adder_top] ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(result);
    end

    function automatic in_item_t noise_item();
        logic [47:0] raw;
        raw = 48'({$urandom, $urandom});
        return raw;
    endfunction

    // well-formed date-time, pushed toward year, month, day, hour and minute boundaries
    function automatic in_item_t calendar_item();
        in_item_t it;
        int unsigned y, m, len;
        case ($urandom_range(9))
            0: y = $urandom_range(1) ? 9999 : 1;
            1: y = 400 * $urandom_range(24, 1);
            2: y = 100 * $urandom_range(99, 1);
            3: y = 4 * $urandom_range(2499, 1);
            default: y = $urandom_range(9999, 1);
        endcase
        m = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 12 : 2) : $urandom_range(12, 1);
        len = dt_scoreboard::days_in(y, m);
        it.in_year = 14'(y);
        it.in_month = 4'(m);
        it.in_day = ($urandom_range(2) == 0) ? 5'(len) : 5'($urandom_range(len, 1));
        it.in_hour = ($urandom_range(2) == 0) ? 5'd23 : 5'($urandom_range(23));
        it.in_minute = ($urandom_range(2) == 0) ? 6'd59 : 6'($urandom_range(59));
        it.in_second = 6'($urandom_range(59));
        return it;
    endfunction

    task automatic send_item(input in_item_t it, input int unsigned idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            item <= noise_item();
            @(posedge clk);
        end
        start <= 1'b1;
        item <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_item(it);
    endtask

    task automatic finish_burst();
        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_step(input int unsigned s);
        cfg_we <= 1'b1;
        cfg_data <= ADD_W'(s);
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_step(s);
    endtask

    task automatic run_directed();
        in_item_t list[$];
        list.push_back('{14'd1, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0});
        list.push_back('{14'd9999, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59});
        list.push_back('{14'd16383, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59});
        list.push_back('{14'd2000, 4'd2, 5'd28, 5'd23, 6'd59, 6'd59});
        list.push_back('{14'd2000, 4'd2, 5'd29, 5'd23, 6'd59, 6'd59});
        list.push_back('{14'd1900, 4'd2, 5'd28, 5'd23, 6'd59, 6'd59});
        list.push_back('{14'd2024, 4'd2, 5'd28, 5'd23, 6'd59, 6'd59});
        list.push_back('{14'd2023, 4'd2, 5'd28, 5'd23, 6'd59, 6'd59});
        list.push_back('{14'd2023, 4'd4, 5'd30, 5'd23, 6'd59, 6'd45});
        list.push_back('{14'd2023, 4'd7, 5'd31, 5'd23, 6'd59, 6'd50});
        list.push_back('{14'd2023, 4'd6, 5'd15, 5'd12, 6'd30, 6'd10});
        // out of range fields
        list.push_back('{14'd2023, 4'd0, 5'd31, 5'd23, 6'd59, 6'd59});
        list.push_back('{14'd2023, 4'd13, 5'd31, 5'd23, 6'd59, 6'd59});
        list.push_back('{14'd2023, 4'd15, 5'd31, 5'd23, 6'd59, 6'd59});
        list.push_back('{14'd2023, 4'd4, 5'd31, 5'd23, 6'd59, 6'd59});
        list.push_back('{14'd2023, 4'd2, 5'd31, 5'd31, 6'd63, 6'd63});
        list.push_back('{14'd2023, 4'd5, 5'd0, 5'd10, 6'd0, 6'd0});
        list.push_back('{14'd2023, 4'd5, 5'd0, 5'd23, 6'd59, 6'd59});
        list.push_back('{14'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0});
        list.push_back('{14'h3fff, 4'hf, 5'h1f, 5'h1f, 6'h3f, 6'h3f});
        foreach (list[i])
            send_item(list[i], 0);
        finish_burst();
    endtask

    initial
    begin
        int unsigned steps[6];
        int unsigned idle_rates[3];
        steps = '{0, 86399, 131071, 1, 3599, 0};
        steps[5] = $urandom_range(86399);
        idle_rates = '{0, 64, 22};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        write_step(131071);
        run_directed();

        for (int p = 0; p < 6; p++)
        begin
            write_step(steps[p]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if ($urandom_range(99) < 15)
                    send_item(noise_item(), idle_rates[p % 3]);
                else
                    send_item(calendar_item(), idle_rates[p % 3]);
            end
            finish_burst();
        end

        repeat (PIPE_DEPTH * 3) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[date_time_seconds_adder_top] OK");
        else
            $display("[date_time_seconds_adder_top] ERROR");
        $finish;
    end

endmodule
